/* rtl/chr_pkg.sv */
// chr_pkg: shared types and constants of the consistent hash ring table.
// Used by chr_cell, chr_ring and consistent_hash_ring_table.
`default_nettype none
package chr_pkg;

    localparam int DEF_MAX_POINTS = 256;
    localparam int DEF_MAX_NODES  = 256;
    localparam int POINT_W        = 32;
    localparam int ID_W           = 8;
    localparam int OWN_W          = ID_W + 1;
    localparam int CFG_W          = 9;
    localparam int DIV_STEPS      = POINT_W + 1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EXISTS  = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_TAKEN   = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;

    localparam logic [1:0] MODE_LOOKUP  = 2'd0;
    localparam logic [1:0] MODE_ADD     = 2'd1;
    localparam logic [1:0] MODE_REPLICA = 2'd2;
    localparam logic [1:0] MODE_REMOVE  = 2'd3;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_FILL,
        OP_INSERT,
        OP_SET_OWNER,
        OP_MARK,
        OP_COMPACT,
        OP_PROBE_GT,
        OP_PROBE_EQ
    } cell_op_t;

    typedef struct packed {
        logic               occ;
        logic [POINT_W-1:0] val;
        logic [OWN_W-1:0]   own;
    } cell_data_t;

    typedef struct packed {
        cell_op_t           op;
        logic [POINT_W-1:0] key;
        logic [OWN_W-1:0]   owner;
        logic               feed_occ;
    } cmd_t;

endpackage
`default_nettype wire

/* rtl/chr_cell.sv */
// chr_cell: one ring slot holding a point value and its owner.
// Depends on chr_pkg; instantiated in a row by chr_ring.
`default_nettype none
module chr_cell import chr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       cmd,
    input  cell_data_t left_i,
    input  logic       left_lt,
    input  logic       left_gt,
    input  cell_data_t right_i,
    output cell_data_t data_o,
    output logic       lt_o,
    output logic       gt_o,
    output logic       hit_o,
    output logic       unsettled_o,
    output cell_data_t sel_o
);

    logic               occ_reg, occ_next;
    logic [POINT_W-1:0] val_reg, val_next;
    logic [OWN_W-1:0]   own_reg, own_next;
    logic               hit_reg, hit_next;
    cell_data_t         sel_reg, sel_next;
    logic               eq;

    assign data_o      = '{occ: occ_reg, val: val_reg, own: own_reg};
    assign lt_o        = occ_reg && (val_reg < cmd.key);
    assign gt_o        = occ_reg && (val_reg > cmd.key);
    assign eq          = occ_reg && (val_reg == cmd.key);
    assign unsettled_o = !occ_reg && right_i.occ;
    assign hit_o       = hit_reg;
    assign sel_o       = sel_reg;

    always_comb begin
        occ_next = occ_reg;
        val_next = val_reg;
        own_next = own_reg;
        hit_next = hit_reg;
        sel_next = sel_reg;
        case (cmd.op)
            OP_FILL: begin
                occ_next = right_i.occ;
                val_next = right_i.val;
                own_next = right_i.own;
            end
            OP_INSERT: begin
                if (!lt_o) begin
                    if (left_lt) begin
                        occ_next = 1'b1;
                        val_next = cmd.key;
                        own_next = cmd.owner;
                    end else begin
                        occ_next = left_i.occ;
                        val_next = left_i.val;
                        own_next = left_i.own;
                    end
                end
            end
            OP_SET_OWNER: begin
                if (eq) own_next = cmd.owner;
            end
            OP_MARK: begin
                if (occ_reg && own_reg == cmd.owner) begin
                    occ_next = 1'b0;
                    own_next = '0;
                end
            end
            OP_COMPACT: begin
                if (!occ_reg && right_i.occ) begin
                    occ_next = 1'b1;
                    val_next = right_i.val;
                    own_next = right_i.own;
                end else if (occ_reg && !left_i.occ) begin
                    occ_next = 1'b0;
                    own_next = '0;
                end
            end
            OP_PROBE_GT: begin
                hit_next = gt_o && !left_gt;
                sel_next = hit_next ? data_o : '0;
            end
            OP_PROBE_EQ: begin
                hit_next = eq;
                sel_next = eq ? data_o : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
            hit_reg <= hit_next;
        end
        val_reg <= val_next;
        own_reg <= own_next;
        sel_reg <= sel_next;
    end

endmodule
`default_nettype wire

/* rtl/chr_ring.sv */
// chr_ring: row of chr_cell slots kept in ascending order, plus OR reductions.
// Depends on chr_pkg and chr_cell.
`default_nettype none
module chr_ring import chr_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       cmd,
    output logic       any_hit,
    output cell_data_t sel_or,
    output logic       any_unsettled,
    output cell_data_t first_data,
    output logic       last_occ
);

    cell_data_t             cd   [MAX_POINTS];
    cell_data_t             sel  [MAX_POINTS];
    cell_data_t             lin  [MAX_POINTS];
    cell_data_t             rin  [MAX_POINTS];
    logic [MAX_POINTS-1:0]  lt, gt, hit, uns, llt, lgt;

    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign lin[i] = '{occ: 1'b1, val: '0, own: '0};
            assign llt[i] = 1'b1;
            assign lgt[i] = 1'b0;
        end else begin : g_mid
            assign lin[i] = cd[i-1];
            assign llt[i] = lt[i-1];
            assign lgt[i] = gt[i-1];
        end
        if (i == MAX_POINTS - 1) begin : g_last
            assign rin[i] = '{occ: cmd.feed_occ, val: cmd.key, own: '0};
        end else begin : g_inner
            assign rin[i] = cd[i+1];
        end
        chr_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .left_i      (lin[i]),
            .left_lt     (llt[i]),
            .left_gt     (lgt[i]),
            .right_i     (rin[i]),
            .data_o      (cd[i]),
            .lt_o        (lt[i]),
            .gt_o        (gt[i]),
            .hit_o       (hit[i]),
            .unsettled_o (uns[i]),
            .sel_o       (sel[i])
        );
    end

    always_comb begin
        sel_or = '0;
        for (int i = 0; i < MAX_POINTS; i++) begin
            sel_or = sel_or | sel[i];
        end
    end

    assign any_hit       = |hit;
    assign any_unsettled = |uns;
    assign first_data    = cd[0];
    assign last_occ      = cd[MAX_POINTS-1].occ;

endmodule
`default_nettype wire

/* rtl/consistent_hash_ring_table.sv */
// consistent_hash_ring_table: top level, sequencer, node register and APB port.
// Depends on chr_pkg and chr_ring.
//
//   port group   dir  flow     words
//   s_*          in   valid/ready  mode, search_key, ring_position, node_id
//   m_*          out  valid/ready  status, owner_valid, owner_node, selected_point
//   p*           in   APB      initial_points at address 0
//
// Lookup: start, probe, reduce, decide, done; an empty ring skips to done.
// Add node / replica: the same, or straight to done when refused up front. Remove:
// start, mark, compaction while a hole travels up to MAX_POINTS positions; unknown node: done.
// After reset and after each config write the table is rebuilt with s_ready low:
// every node slot is cleared, the point spacing is divided out, then every ring slot is filled.
// A held result stalls completion of the next item, not its acceptance.
`default_nettype none
module consistent_hash_ring_table import chr_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int MAX_NODES  = DEF_MAX_NODES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic [POINT_W-1:0]  s_search_key,
    input  logic [POINT_W-1:0]  s_ring_position,
    input  logic [ID_W-1:0]     s_node_id,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic                m_owner_valid,
    output logic [ID_W-1:0]     m_owner_node,
    output logic [POINT_W-1:0]  m_selected_point,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int NIW = $clog2(MAX_NODES);

    typedef enum logic [3:0] {
        S_CLEAR, S_DIV, S_FILL, S_IDLE, S_START, S_PROBE, S_REDUCE,
        S_DECIDE, S_MARK, S_COMPACT, S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     init_reg;
    logic [5:0]           div_cnt_reg, div_cnt_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic [DIV_STEPS-1:0] q_reg, q_next;
    logic [POINT_W-1:0]   acc_reg, acc_next;
    logic [CW-1:0]        fill_reg, fill_next;
    cmd_t                 cmd_reg, cmd_next;
    logic                 present_mem [MAX_NODES];
    logic                 known_reg;
    logic [NIW-1:0]       clr_reg, clr_next;
    logic [1:0]           mode_reg;
    logic [POINT_W-1:0]   key_reg, pos_reg;
    logic [ID_W-1:0]      id_reg;
    logic                 any_hit_reg;
    cell_data_t           sel_reg;
    logic [2:0]           rs_reg, rs_next;
    logic                 rv_reg, rv_next;
    logic [ID_W-1:0]      rn_reg, rn_next;
    logic [POINT_W-1:0]   rp_reg, rp_next;
    logic                 m_valid_reg;
    logic [2:0]           m_status_reg;
    logic                 m_owner_valid_reg;
    logic [ID_W-1:0]      m_owner_node_reg;
    logic [POINT_W-1:0]   m_selected_point_reg;

    logic                 any_hit, any_unsettled, last_occ;
    cell_data_t           sel_or, first_data, pick;
    logic [CW-1:0]        n_pts;
    logic [CW:0]          rem_sh;
    logic                 ge, cfg_wr, in_range, known, out_free;
    logic [NIW-1:0]       idx;
    logic                 pres_we, pres_wd;
    logic [NIW-1:0]       pres_wa;

    chr_ring #(.MAX_POINTS(MAX_POINTS)) u_ring (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd_reg),
        .any_hit       (any_hit),
        .sel_or        (sel_or),
        .any_unsettled (any_unsettled),
        .first_data    (first_data),
        .last_occ      (last_occ)
    );

    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {{(32-CFG_W){1'b0}}, init_reg} : '0;
    assign pready   = 1'b1;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_owner_valid    = m_owner_valid_reg;
    assign m_owner_node     = m_owner_node_reg;
    assign m_selected_point = m_selected_point_reg;

    assign n_pts = (init_reg == '0) ? CW'(1) :
                   (32'(init_reg) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(init_reg);
    assign rem_sh   = {rem_reg, (div_cnt_reg == '0)};
    assign ge       = rem_sh >= {1'b0, n_pts};
    assign in_range = 32'(id_reg) < MAX_NODES;
    assign idx      = NIW'(id_reg);
    assign known    = in_range && known_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign pick     = any_hit_reg ? sel_reg : first_data;

    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        acc_next     = acc_reg;
        fill_next    = fill_reg;
        clr_next     = clr_reg;
        pres_we      = 1'b0;
        pres_wd      = 1'b0;
        pres_wa      = idx;
        rs_next      = rs_reg;
        rv_next      = rv_reg;
        rn_next      = rn_reg;
        rp_next      = rp_reg;
        cmd_next     = '{op: OP_NOP, key: cmd_reg.key, owner: cmd_reg.owner, feed_occ: 1'b0};
        case (state_reg)
            S_CLEAR: begin
                pres_we  = 1'b1;
                pres_wa  = clr_reg;
                clr_next = clr_reg + NIW'(1);
                if (32'(clr_reg) == MAX_NODES - 1) state_next = S_DIV;
            end
            S_DIV: begin
                rem_next     = ge ? CW'(rem_sh - {1'b0, n_pts}) : CW'(rem_sh);
                q_next       = {q_reg[DIV_STEPS-2:0], ge};
                div_cnt_next = div_cnt_reg + 6'd1;
                if (32'(div_cnt_reg) == DIV_STEPS - 1) begin
                    state_next = S_FILL;
                    acc_next   = '0;
                    fill_next  = '0;
                end
            end
            S_FILL: begin
                cmd_next  = '{op: OP_FILL, key: acc_reg, owner: '0,
                              feed_occ: (fill_reg < n_pts)};
                acc_next  = acc_reg + q_reg[POINT_W-1:0];
                fill_next = fill_reg + CW'(1);
                if (32'(fill_reg) == MAX_POINTS - 1) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) state_next = S_START;
            end
            S_START: begin
                rs_next = ST_OK;
                rv_next = 1'b0;
                rn_next = '0;
                rp_next = '0;
                state_next = S_DONE;
                case (mode_reg)
                    MODE_LOOKUP: begin
                        if (!first_data.occ) begin
                            rs_next = ST_EMPTY;
                        end else begin
                            cmd_next.op  = OP_PROBE_GT;
                            cmd_next.key = key_reg;
                            state_next   = S_PROBE;
                        end
                    end
                    MODE_ADD: begin
                        if (!in_range) begin
                            rs_next = ST_FULL;
                        end else if (known) begin
                            rs_next = ST_EXISTS;
                        end else begin
                            cmd_next.op  = OP_PROBE_EQ;
                            cmd_next.key = pos_reg;
                            state_next   = S_PROBE;
                        end
                    end
                    MODE_REPLICA: begin
                        if (!known) begin
                            rs_next = ST_MISSING;
                        end else begin
                            cmd_next.op  = OP_PROBE_EQ;
                            cmd_next.key = pos_reg;
                            state_next   = S_PROBE;
                        end
                    end
                    default: begin
                        if (known) begin
                            cmd_next.op    = OP_MARK;
                            cmd_next.owner = {1'b1, id_reg};
                            pres_we        = 1'b1;
                            state_next = S_MARK;
                        end
                    end
                endcase
            end
            S_PROBE: begin
                state_next = S_REDUCE;
            end
            S_REDUCE: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                state_next = S_DONE;
                if (mode_reg == MODE_LOOKUP) begin
                    rp_next = pick.val;
                    rv_next = pick.own[OWN_W-1];
                    rn_next = pick.own[OWN_W-1] ? pick.own[ID_W-1:0] : '0;
                end else if (any_hit_reg && sel_reg.own[OWN_W-1]) begin
                    if (mode_reg == MODE_ADD) begin
                        pres_we = 1'b1;
                        pres_wd = 1'b1;
                    end else begin
                        rs_next = ST_TAKEN;
                    end
                end else if (any_hit_reg) begin
                    cmd_next.op    = OP_SET_OWNER;
                    cmd_next.key   = pos_reg;
                    cmd_next.owner = {1'b1, id_reg};
                    if (mode_reg == MODE_ADD) begin
                        pres_we = 1'b1;
                        pres_wd = 1'b1;
                    end
                end else if (last_occ) begin
                    rs_next = ST_FULL;
                end else begin
                    cmd_next.op    = OP_INSERT;
                    cmd_next.key   = pos_reg;
                    cmd_next.owner = {1'b1, id_reg};
                    if (mode_reg == MODE_ADD) begin
                        pres_we = 1'b1;
                        pres_wd = 1'b1;
                    end
                end
            end
            S_MARK: begin
                cmd_next.op = OP_COMPACT;
                state_next  = S_COMPACT;
            end
            S_COMPACT: begin
                if (any_unsettled) cmd_next.op = OP_COMPACT;
                else state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_wr) begin
            state_next   = S_CLEAR;
            clr_next     = '0;
            div_cnt_next = '0;
            rem_next     = '0;
            q_next       = '0;
            pres_we      = 1'b0;
            cmd_next.op  = OP_NOP;
        end
    end

    always_ff @(posedge aclk) begin
        if (aresetn && pres_we) present_mem[pres_wa] <= pres_wd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            init_reg    <= CFG_W'(1);
            clr_reg     <= '0;
            div_cnt_reg <= '0;
            rem_reg     <= '0;
            q_reg       <= '0;
            fill_reg    <= '0;
            cmd_reg     <= '{op: OP_NOP, key: '0, owner: '0, feed_occ: 1'b0};
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_wr) init_reg <= pwdata[CFG_W-1:0];
            clr_reg     <= clr_next;
            div_cnt_reg <= div_cnt_next;
            rem_reg     <= rem_next;
            q_reg       <= q_next;
            fill_reg    <= fill_next;
            cmd_reg     <= cmd_next;
            if (state_reg == S_DONE && out_free) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
        acc_reg <= acc_next;
        rs_reg  <= rs_next;
        rv_reg  <= rv_next;
        rn_reg  <= rn_next;
        rp_reg  <= rp_next;
        any_hit_reg <= any_hit;
        sel_reg     <= sel_or;
        if (s_valid && s_ready) begin
            mode_reg  <= s_mode;
            key_reg   <= s_search_key;
            pos_reg   <= s_ring_position;
            id_reg    <= s_node_id;
            known_reg <= present_mem[NIW'(s_node_id)];
        end
        if (state_reg == S_DONE && out_free) begin
            m_status_reg         <= rs_reg;
            m_owner_valid_reg    <= rv_reg;
            m_owner_node_reg     <= rn_reg;
            m_selected_point_reg <= rp_reg;
        end
    end

endmodule
`default_nettype wire
